// ===== src/ifst_pkg.sv =====
`default_nettype none

package ifst_pkg;

  localparam int unsigned AddrW   = 48;
  localparam int unsigned LatW    = 16;
  localparam int unsigned CycW    = 48;
  localparam int unsigned CntW    = 32;
  localparam int unsigned LineW   = 42;
  localparam int unsigned FillsW  = 4;

  // Input tdata: fetch_address, fill_latency.
  localparam int unsigned InDataW  = AddrW + LatW;
  // Output tdata: ready_cycle, instruction_count (80 bits, whole bytes).
  localparam int unsigned OutDataW = CycW + CntW;

  localparam logic [CycW-1:0]   CycMax     = '1;
  localparam logic [CntW-1:0]   CntMax     = '1;
  localparam logic [FillsW-1:0] FillsReset = 4'd8;

  // One slot of the fill table as kept in the slot RAM.
  typedef struct packed {
    logic [LineW-1:0] line;
    logic [CycW-1:0]  comp;
  } slot_entry_t;

  localparam int unsigned EntryW = $bits(slot_entry_t);

endpackage

`default_nettype wire

// ===== src/ifst_ram.sv =====
`default_nettype none

module ifst_ram #(
  parameter int unsigned Width = 90,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/icache_fill_slot_timing_core.sv =====
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata {latency, fetch_address},
//                                                    tlast window_end
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata {instruction_count, ready_cycle},
//                                                    tuser line_in_flight, tlast window_done
// cfg       in         cfg_valid_i/cfg_ready_o       max_fills
//
// Each item makes one or more passes over the slot RAM, one slot per cycle through the
// shared compare unit; a miss needs one more pass per eviction. Reset clears the slot
// valid bits and the window state; no RAM sweep. A result waiting in the output
// register only holds the block once the next item reaches its final state, S_FIN.
`default_nettype none

module icache_fill_slot_timing_core #(
  parameter int unsigned FILL_SLOTS = 8,
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [47:0] fetch_address, [63:48] latency
  input  logic [ifst_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tlast,

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [47:0] ready_cycle, [79:48] instruction_count
  output logic [ifst_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] line_in_flight
  output logic [0:0]                     m_axis_tuser,
  output logic                           m_axis_tlast,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ifst_pkg::FillsW-1:0]    cfg_data_i
);

  import ifst_pkg::*;

  localparam int unsigned IdxW     = (FILL_SLOTS > 1) ? $clog2(FILL_SLOTS) : 1;
  localparam int unsigned SlotCntW = $clog2(FILL_SLOTS + 1);
  localparam int unsigned LimW     = (SlotCntW > FillsW) ? SlotCntW : FillsW;
  localparam int unsigned LineSh   = $clog2(LINE_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [FillsW-1:0]     max_fills_q;
  logic [FILL_SLOTS-1:0] valid_q;
  logic [CycW-1:0]       cur_q;
  logic [CntW-1:0]       seen_q;
  logic                  m_tvalid_q;
  logic                  iss_q;
  logic                  dv_q;

  logic [LineW-1:0]      line_q;
  logic [LatW-1:0]       lat_q;
  logic                  wend_q;
  logic [CycW-1:0]       free_q;
  logic [CycW-1:0]       start_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [IdxW-1:0]       d_idx_q;
  logic                  d_last_q;
  logic                  hit_q;
  logic [CycW-1:0]       hit_comp_q;
  logic                  best_found_q;
  logic [CycW-1:0]       best_comp_q;
  logic [LineW-1:0]      best_line_q;
  logic [IdxW-1:0]       best_idx_q;
  logic                  free_found_q;
  logic [IdxW-1:0]       free_idx_q;
  logic [LimW-1:0]       used_q;
  logic [OutDataW-1:0]   m_data_q;
  logic                  m_user_q;
  logic                  m_last_q;

  logic                  in_acc;
  logic                  rd_last;
  logic                  evict;
  logic                  scan_start;
  logic                  out_load;
  logic                  win_clear;
  logic [LimW-1:0]       fills_ext;
  logic [LimW-1:0]       lim;
  logic [AddrW-1:0]      addr_sh;
  logic [CycW:0]         sum;
  logic [CycW-1:0]       done_cyc;
  logic [CntW-1:0]       seen_next;
  slot_entry_t           rd_entry;
  slot_entry_t           wr_entry;
  logic                  better;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign fills_ext = LimW'(max_fills_q);
  assign lim = (fills_ext == '0) ? LimW'(1) :
               (fills_ext > LimW'(FILL_SLOTS)) ? LimW'(FILL_SLOTS) : fills_ext;

  assign addr_sh = s_axis_tdata[AddrW-1:0] >> LineSh;
  assign rd_last = (rd_idx_q == IdxW'(FILL_SLOTS - 1));

  assign evict      = (state_q == S_EVAL) && !hit_q && (used_q >= lim);
  assign scan_start = in_acc || evict;
  assign out_load   = (state_q == S_FIN) && (!m_tvalid_q || m_axis_tready);
  assign win_clear  = out_load && wend_q;

  assign sum       = {1'b0, start_q} + (CycW + 1)'(lat_q);
  assign done_cyc  = sum[CycW] ? CycMax : sum[CycW-1:0];
  assign seen_next = (seen_q == CntMax) ? seen_q : seen_q + CntW'(1);

  // Shared compare unit: candidate beats the current earliest completion,
  // with the lower line winning a tie.
  assign better = !best_found_q || (rd_entry.comp < best_comp_q) ||
                  ((rd_entry.comp == best_comp_q) && (rd_entry.line < best_line_q));

  assign wr_entry.line = line_q;
  assign wr_entry.comp = done_cyc;

  ifst_ram #(
    .Width (EntryW),
    .Depth (FILL_SLOTS),
    .AddrW (IdxW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_ADD),
    .waddr_i (free_idx_q),
    .wdata_i (wr_entry),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_entry)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (dv_q && d_last_q) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (hit_q) begin
          state_d = S_FIN;
        end else if (evict) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_START;
        end
      end
      S_START: state_d = S_ADD;
      S_ADD:   state_d = S_FIN;
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_fills_q <= FillsReset;
      valid_q     <= '0;
      cur_q       <= '0;
      seen_q      <= '0;
      m_tvalid_q  <= 1'b0;
      iss_q       <= 1'b0;
      dv_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        max_fills_q <= cfg_data_i;
      end

      if (scan_start) begin
        iss_q <= 1'b1;
        dv_q  <= 1'b0;
      end else if (state_q == S_SCAN) begin
        dv_q <= iss_q;
        if (iss_q && rd_last) iss_q <= 1'b0;
      end

      if (state_q == S_EVAL && hit_q && hit_comp_q > cur_q) begin
        cur_q <= hit_comp_q;
      end
      if (evict) begin
        valid_q[best_idx_q] <= 1'b0;
      end
      if (state_q == S_ADD) begin
        cur_q               <= done_cyc;
        valid_q[free_idx_q] <= 1'b1;
      end

      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end

      // The window's last item clears the slot table and counters.
      if (win_clear) begin
        valid_q <= '0;
        cur_q   <= '0;
        seen_q  <= '0;
      end else if (out_load) begin
        seen_q <= seen_next;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_q <= addr_sh[LineW-1:0];
      lat_q  <= s_axis_tdata[AddrW +: LatW];
      wend_q <= s_axis_tlast;
      free_q <= cur_q;
    end
    if (evict) begin
      free_q <= best_comp_q;
    end

    if (scan_start) begin
      rd_idx_q     <= '0;
      hit_q        <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      used_q       <= '0;
    end else if (state_q == S_SCAN) begin
      d_idx_q  <= rd_idx_q;
      d_last_q <= rd_last;
      if (iss_q && !rd_last) rd_idx_q <= rd_idx_q + IdxW'(1);
      if (dv_q) begin
        if (valid_q[d_idx_q]) begin
          used_q <= used_q + LimW'(1);
          if (!hit_q && rd_entry.line == line_q) begin
            hit_q      <= 1'b1;
            hit_comp_q <= rd_entry.comp;
          end
          if (better) begin
            best_found_q <= 1'b1;
            best_comp_q  <= rd_entry.comp;
            best_line_q  <= rd_entry.line;
            best_idx_q   <= d_idx_q;
          end
        end else if (!free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= d_idx_q;
        end
      end
    end

    if (state_q == S_START) begin
      start_q <= (cur_q > free_q) ? cur_q : free_q;
    end

    if (out_load) begin
      m_data_q <= {seen_next, cur_q};
      m_user_q <= hit_q;
      m_last_q <= wend_q;
    end
  end

  assign m_axis_tvalid   = m_tvalid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;
  assign m_axis_tlast    = m_last_q;

`ifndef SYNTHESIS
  // A new fill always lands in a slot the scan found free.
  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> (free_found_q && !valid_q[free_idx_q]))
    else $error("fill allocated into an occupied or unknown slot");

  // Within a window the ready cycle never moves backward.
  a_ready_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && !$past(win_clear)) |-> (cur_q >= $past(cur_q)))
    else $error("ready cycle decreased inside a window");

  // The window's last result leaves an empty table behind.
  a_win_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_clear |=> (valid_q == '0 && cur_q == '0 && seen_q == '0))
    else $error("window state not cleared after window end");

  // An eviction pass only starts when some slot was found to evict.
  a_evict_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict |-> (best_found_q && valid_q[best_idx_q]))
    else $error("eviction without a valid victim");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ifst_pkg::*;

  localparam int unsigned FILL_SLOTS     = 8;
  localparam int unsigned LINE_BYTES     = 64;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_FETCHES = 640;

  typedef struct packed {
    logic [CycW-1:0] ready_cycle;
    logic            in_flight;
    logic [CntW-1:0] count;
    logic            done;
  } fetch_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [FillsW-1:0]   cfg_data_i    = '0;

  // Predicted state of the fill table and the window.
  logic [LineW-1:0]  model_line  [FILL_SLOTS];
  logic [CycW-1:0]   model_comp  [FILL_SLOTS];
  logic              model_valid [FILL_SLOTS];
  logic [CycW-1:0]   model_ready;
  logic [CntW-1:0]   model_count;
  logic [FillsW-1:0] model_max_fills;

  fetch_result_t pending_results[$];

  bit steady;
  bit hold_requested;
  int unsigned errors;
  int unsigned fetches_sent;
  int unsigned results_checked;
  int unsigned line_hits;
  int unsigned windows_closed;
  int unsigned limit_writes;
  int unsigned quiet_cycles;

  icache_fill_slot_timing_core #(
    .FILL_SLOTS(FILL_SLOTS),
    .LINE_BYTES(LINE_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #10ns clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [AddrW-1:0] line_addr(input int unsigned line_no);
    return AddrW'(line_no * LINE_BYTES);
  endfunction

  function automatic void clear_window_model();
    for (int i = 0; i < FILL_SLOTS; i++) begin
      model_line[i]  = '0;
      model_comp[i]  = '0;
      model_valid[i] = 1'b0;
    end
    model_ready = '0;
    model_count = '0;
  endfunction

  // Walks the fill table for one fetch and returns the timing it should report.
  function automatic fetch_result_t predict_fetch(input logic [AddrW-1:0] addr,
                                                  input logic [LatW-1:0] lat,
                                                  input logic wend);
    fetch_result_t res;
    logic [LineW-1:0] line_no;
    logic [CycW-1:0] free_cycle;
    logic [CycW-1:0] start;
    logic [CycW:0] sum;
    int hit;
    int best;
    int used;
    int lim;
    line_no = LineW'(addr / LINE_BYTES);
    hit = -1;
    for (int i = 0; i < FILL_SLOTS; i++) begin
      if (hit < 0 && model_valid[i] && model_line[i] == line_no) hit = i;
    end
    if (hit >= 0) begin
      if (model_comp[hit] > model_ready) model_ready = model_comp[hit];
    end else begin
      lim = int'(model_max_fills);
      if (lim < 1) lim = 1;
      if (lim > FILL_SLOTS) lim = FILL_SLOTS;
      used = 0;
      for (int i = 0; i < FILL_SLOTS; i++) used += model_valid[i];
      free_cycle = model_ready;
      // A lowered limit can force several evictions; the last one sets the free cycle.
      while (used >= lim) begin
        best = -1;
        for (int i = 0; i < FILL_SLOTS; i++) begin
          if (model_valid[i] && (best < 0 || model_comp[i] < model_comp[best] ||
              (model_comp[i] == model_comp[best] && model_line[i] < model_line[best])))
            best = i;
        end
        free_cycle = model_comp[best];
        model_valid[best] = 1'b0;
        used--;
      end
      start = (model_ready > free_cycle) ? model_ready : free_cycle;
      sum = {1'b0, start} + (CycW+1)'(lat);
      model_ready = (sum > {1'b0, CycMax}) ? CycMax : sum[CycW-1:0];
      best = -1;
      for (int i = 0; i < FILL_SLOTS; i++) begin
        if (best < 0 && !model_valid[i]) best = i;
      end
      model_line[best]  = line_no;
      model_comp[best]  = model_ready;
      model_valid[best] = 1'b1;
    end
    if (model_count != CntMax) model_count++;
    res.ready_cycle = model_ready;
    res.in_flight   = (hit >= 0);
    res.count       = model_count;
    res.done        = wend;
    if (wend) clear_window_model();
    return res;
  endfunction

  task automatic send_fetch(input logic [AddrW-1:0] addr, input logic [LatW-1:0] lat,
                            input logic wend);
    int gap;
    fetch_result_t exp_res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lat, addr};
    s_axis_tlast  <= wend;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_res = predict_fetch(addr, lat, wend);
    pending_results = {pending_results, exp_res};
    fetches_sent++;
    if (wend) windows_closed++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_fills(input logic [FillsW-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_max_fills = value;
    limit_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    fetch_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: ready %0d count %0d", $time,
                 m_axis_tdata[CycW-1:0], m_axis_tdata[CycW+CntW-1:CycW]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.in_flight) line_hits++;
        if (m_axis_tdata[CycW-1:0] !== want.ready_cycle) begin
          $display("%0t: ready_cycle expected %0d, got %0d", $time, want.ready_cycle,
                   m_axis_tdata[CycW-1:0]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.in_flight) begin
          $display("%0t: line_in_flight expected %0b, got %0b", $time, want.in_flight,
                   m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata[CycW+CntW-1:CycW] !== want.count) begin
          $display("%0t: instruction_count expected %0d, got %0d", $time, want.count,
                   m_axis_tdata[CycW+CntW-1:CycW]);
          errors++;
        end
        if (m_axis_tlast !== want.done) begin
          $display("%0t: window_done expected %0b, got %0b", $time, want.done,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off when a test asks for it.
  initial begin
    int stall;
    forever begin
      if (hold_requested) begin
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        hold_requested = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_field_extremes();
    send_fetch('0, '0, 1'b0);
    send_fetch(AddrW'(LINE_BYTES - 1), '1, 1'b0);
    send_fetch('1, '1, 1'b0);
    send_fetch({{(AddrW-6){1'b1}}, 6'd0}, '0, 1'b0);
    send_fetch(48'hAAAA_AAAA_AAAA, 16'h5555, 1'b0);
    send_fetch(48'h5555_5555_5555, 16'hAAAA, 1'b1);
  endtask

  // Equal completion cycles must evict the lowest line first.
  task automatic test_eviction_ties();
    write_max_fills(4'd2);
    send_fetch(line_addr(5), '0, 1'b0);
    send_fetch(line_addr(3), '0, 1'b0);
    send_fetch(line_addr(9), 16'd10, 1'b0);
    send_fetch(line_addr(3) + 7, 16'd4, 1'b0);
    send_fetch(line_addr(9), 16'd1, 1'b1);
  endtask

  task automatic test_slot_limit_clamp();
    write_max_fills(4'd0);
    send_fetch(line_addr(1), 16'd7, 1'b0);
    send_fetch(line_addr(2), 16'd3, 1'b0);
    send_fetch(line_addr(2) + 1, 16'd9, 1'b0);
    write_max_fills(4'd15);
    for (int k = 0; k < 9; k++) send_fetch(line_addr(20 + k), 16'(k * 5), 1'b0);
  endtask

  // The window stays open while the limit drops, so many evictions happen at once.
  task automatic test_limit_lowered();
    write_max_fills(4'd2);
    send_fetch(line_addr(40), 16'd2, 1'b0);
    send_fetch(line_addr(40), 16'd2, 1'b1);
  endtask

  task automatic test_random_windows();
    logic [FillsW-1:0] limits[9] = '{4'd8, 4'd1, 4'd4, 4'd2, 4'd15, 4'd3, 4'd0, 4'd6, 4'd8};
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] addr;
    logic [LatW-1:0] lat;
    int roll;
    base = AddrW'({$urandom, $urandom});
    for (int p = 0; p < 9; p++) begin
      write_max_fills(limits[p]);
      steady = (p % 3 == 1);
      for (int n = 0; n < RANDOM_FETCHES / 9; n++) begin
        // Most fetches stay within a dozen lines so that hits and evictions are common.
        if ($urandom_range(9) < 8)
          addr = base + line_addr($urandom_range(11)) + AddrW'($urandom_range(63));
        else
          addr = AddrW'({$urandom, $urandom});
        roll = $urandom_range(9);
        if (roll == 0) lat = '0;
        else if (roll == 1) lat = '1;
        else if (roll < 7) lat = LatW'($urandom_range(200, 1));
        else lat = LatW'($urandom);
        if ($urandom_range(19) == 0) begin
          send_fetch(addr, lat, 1'b1);
          base = AddrW'({$urandom, $urandom});
        end else begin
          send_fetch(addr, lat, 1'b0);
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    steady = 1'b1;
    hold_requested = 1'b1;
    for (int n = 0; n < 30; n++)
      send_fetch(line_addr($urandom_range(15)), LatW'($urandom_range(50)), n == 29);
    steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 12; n++)
      send_fetch(line_addr($urandom_range(9)), LatW'($urandom_range(30)), 1'b0);
    wait_drained();
    for (int n = 0; n < 12; n++)
      send_fetch(line_addr($urandom_range(9)), LatW'($urandom_range(30)), n == 11);
  endtask

  initial begin
    model_max_fills = FillsReset;
    clear_window_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_eviction_ties();
    test_slot_limit_clamp();
    test_limit_lowered();
    test_random_windows();
    test_output_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d fetches in %0d windows with %0d slot-limit writes (0 to 15).",
             fetches_sent, windows_closed, limit_writes);
    $display("Checked %0d results, %0d of them hits on a line in flight; %0d errors.",
             results_checked, line_hits, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ifst_pkg.sv
src/ifst_ram.sv
src/icache_fill_slot_timing_core.sv
tb/sv/testbench.sv
